### rtl/slx_pkg.sv
// Shared types and constants for the source lexer.
// Lexer modes, token kind codes, result record and character codes.
// No dependencies.
package slx_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 5;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'd0,
        MODE_NAME    = 5'd1,
        MODE_INT     = 5'd2,
        MODE_INTDOT  = 5'd3,
        MODE_FLOAT   = 5'd4,
        MODE_SLASH   = 5'd5,
        MODE_COMMENT = 5'd6,
        MODE_EQ      = 5'd7,
        MODE_BANG    = 5'd8,
        MODE_PLUS    = 5'd9,
        MODE_MINUS   = 5'd10,
        MODE_LT      = 5'd11,
        MODE_GT      = 5'd12,
        MODE_AMP     = 5'd13,
        MODE_PIPE    = 5'd14
    } lexer_mode_t;

    typedef enum logic [KIND_W-1:0] {
        K_EOS           = 5'd0,
        K_NAME          = 5'd1,
        K_INT           = 5'd2,
        K_FLOAT         = 5'd3,
        K_SLASH         = 5'd4,
        K_EQUAL_EQUAL   = 5'd5,
        K_EQUAL         = 5'd6,
        K_NOT_EQUAL     = 5'd7,
        K_LOGICAL_NOT   = 5'd8,
        K_PLUS_PLUS     = 5'd9,
        K_PLUS          = 5'd10,
        K_MINUS_MINUS   = 5'd11,
        K_ARROW         = 5'd12,
        K_MINUS         = 5'd13,
        K_STAR          = 5'd14,
        K_LESS_EQUAL    = 5'd15,
        K_LESS          = 5'd16,
        K_GREATER_EQUAL = 5'd17,
        K_GREATER       = 5'd18,
        K_LEFT_PAREN    = 5'd19,
        K_RIGHT_PAREN   = 5'd20,
        K_LOGICAL_AND   = 5'd21,
        K_LOGICAL_OR    = 5'd22,
        K_SEMICOLON     = 5'd23,
        K_LEFT_BRACE    = 5'd24,
        K_RIGHT_BRACE   = 5'd25,
        K_DISCARD       = 5'd26
    } token_kind_t;

    // out_kind codes
    localparam logic OUT_LEXEME = 1'b0;
    localparam logic OUT_DONE   = 1'b1;

    typedef struct packed {
        logic              out_kind;
        token_kind_t       token_kind;
        logic [CHAR_W-1:0] lexeme_char;
        logic              last;
    } lex_result_t;

    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_GREATER    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LESS       = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_AMP        = 8'h26;
    localparam logic [CHAR_W-1:0] CH_PIPE       = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

endpackage

### rtl/slx_in_if.sv
// Character input channel of the source lexer.
// Valid/ready handshake with source and sink modports; uses slx_pkg.
interface slx_in_if
    import slx_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

### rtl/slx_out_if.sv
// Result output channel of the source lexer.
// Valid/ready handshake with source and sink modports; uses slx_pkg.
interface slx_out_if
    import slx_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              out_kind;
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] lexeme_char;
    logic              last;

    modport source (
        output valid, output out_kind, output token_kind, output lexeme_char,
        output last, input ready
    );
    modport sink (
        input valid, input out_kind, input token_kind, input lexeme_char,
        input last, output ready
    );
endinterface

### rtl/source_lexer_core.sv
// Source lexer top level: mode register, next-token logic, result queue.
// Depends on slx_pkg, slx_in_if, slx_out_if.
//
// Usage:
//   chars  : one request per source byte (ch), or an end mark with
//            end_of_input high (ch ignored).
//   tokens : result requests; out_kind 0 streams one lexeme character,
//            out_kind 1 closes a token with token_kind. last flags the
//            final result caused by one input request.
// Each byte is decoded in the cycle it is accepted, against the current
// lexer mode, into zero, one or two results written to a 4-entry result
// queue. When the queue was empty, the first result is visible on tokens
// in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the receiver takes one result per
// cycle and bytes give at most one result each; a byte that gives two
// results holds the output until both are taken. chars.ready is high while
// the queue has room for two results, so a stalled receiver fills the
// queue and then holds off the sender; nothing is dropped.
// Reset empties the queue and returns the lexer to idle mode.
module source_lexer_core
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slx_in_if.sink      chars,
    slx_out_if.source   tokens
);

    localparam int DEPTH = 4;

    lexer_mode_t mode_reg, mode_next;
    lex_result_t fifo_mem [DEPTH];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg, count_next;

    lex_result_t res0, res1;
    logic [1:0]  push_n;
    logic        in_fire, out_fire;

    lex_result_t first_res, idle_res;
    logic        has_first, has_idle, again;
    lexer_mode_t idle_mode;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic lex_result_t lex_char(input logic [CHAR_W-1:0] c);
        lex_result_t r;
        r.out_kind    = OUT_LEXEME;
        r.token_kind  = K_EOS;
        r.lexeme_char = c;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic lex_result_t done(input token_kind_t k);
        lex_result_t r;
        r.out_kind    = OUT_DONE;
        r.token_kind  = k;
        r.lexeme_char = '0;
        r.last        = 1'b0;
        return r;
    endfunction

    assign in_fire  = chars.valid && chars.ready;
    assign out_fire = tokens.valid && tokens.ready;

    // Decode the byte on the input channel against the current mode.
    always_comb
    begin
        logic [CHAR_W-1:0] c;
        c         = chars.ch;
        first_res = done(K_EOS);
        has_first = 1'b0;
        again     = 1'b0;
        mode_next = mode_reg;
        idle_res  = done(K_EOS);
        has_idle  = 1'b0;
        idle_mode = MODE_IDLE;

        if (chars.end_of_input)
        begin
            has_first = 1'b1;
            unique case (mode_reg)
                MODE_NAME:   first_res = done(K_NAME);
                MODE_INT:    first_res = done(K_INT);
                MODE_INTDOT: first_res = done(K_DISCARD);
                MODE_FLOAT:  first_res = done(K_FLOAT);
                MODE_SLASH:  first_res = done(K_SLASH);
                MODE_EQ:     first_res = done(K_EQUAL);
                MODE_BANG:   first_res = done(K_LOGICAL_NOT);
                MODE_PLUS:   first_res = done(K_PLUS);
                MODE_MINUS:  first_res = done(K_MINUS);
                MODE_LT:     first_res = done(K_LESS);
                MODE_GT:     first_res = done(K_GREATER);
                default:     has_first = 1'b0;
            endcase
            idle_res  = done(K_EOS);
            has_idle  = 1'b1;
            mode_next = MODE_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NAME:
                begin
                    has_first = 1'b1;
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE)
                        first_res = lex_char(c);
                    else
                    begin
                        first_res = done(K_NAME);
                        again     = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    has_first = 1'b1;
                    if (is_digit(c))
                        first_res = lex_char(c);
                    else if (c == CH_DOT)
                    begin
                        first_res = lex_char(c);
                        mode_next = MODE_INTDOT;
                    end
                    else
                    begin
                        first_res = done(K_INT);
                        again     = 1'b1;
                    end
                end
                MODE_INTDOT:
                begin
                    has_first = 1'b1;
                    if (is_digit(c))
                    begin
                        first_res = lex_char(c);
                        mode_next = MODE_FLOAT;
                    end
                    else
                    begin
                        first_res = done(K_DISCARD);
                        again     = 1'b1;
                    end
                end
                MODE_FLOAT:
                begin
                    has_first = 1'b1;
                    if (is_digit(c))
                        first_res = lex_char(c);
                    else
                    begin
                        first_res = done(K_FLOAT);
                        again     = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_COMMENT;
                    else
                    begin
                        has_first = 1'b1;
                        first_res = done(K_SLASH);
                        again     = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_NEWLINE)
                        mode_next = MODE_IDLE;
                end
                MODE_EQ:
                begin
                    has_first = 1'b1;
                    if (c == CH_EQUAL)
                    begin
                        first_res = done(K_EQUAL_EQUAL);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_EQUAL);
                        again     = 1'b1;
                    end
                end
                MODE_BANG:
                begin
                    has_first = 1'b1;
                    if (c == CH_EQUAL)
                    begin
                        first_res = done(K_NOT_EQUAL);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_LOGICAL_NOT);
                        again     = 1'b1;
                    end
                end
                MODE_PLUS:
                begin
                    has_first = 1'b1;
                    if (c == CH_PLUS)
                    begin
                        first_res = done(K_PLUS_PLUS);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_PLUS);
                        again     = 1'b1;
                    end
                end
                MODE_LT:
                begin
                    has_first = 1'b1;
                    if (c == CH_EQUAL)
                    begin
                        first_res = done(K_LESS_EQUAL);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_LESS);
                        again     = 1'b1;
                    end
                end
                MODE_GT:
                begin
                    has_first = 1'b1;
                    if (c == CH_EQUAL)
                    begin
                        first_res = done(K_GREATER_EQUAL);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_GREATER);
                        again     = 1'b1;
                    end
                end
                MODE_MINUS:
                begin
                    has_first = 1'b1;
                    if (c == CH_GREATER)
                    begin
                        first_res = done(K_ARROW);
                        mode_next = MODE_IDLE;
                    end
                    else if (c == CH_MINUS)
                    begin
                        first_res = done(K_MINUS_MINUS);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_res = done(K_MINUS);
                        again     = 1'b1;
                    end
                end
                MODE_AMP:
                begin
                    if (c == CH_AMP)
                    begin
                        has_first = 1'b1;
                        first_res = done(K_LOGICAL_AND);
                        mode_next = MODE_IDLE;
                    end
                    else
                        again = 1'b1;   // lone '&' is dropped
                end
                MODE_PIPE:
                begin
                    if (c == CH_PIPE)
                    begin
                        has_first = 1'b1;
                        first_res = done(K_LOGICAL_OR);
                        mode_next = MODE_IDLE;
                    end
                    else
                        again = 1'b1;
                end
                default:
                    again = 1'b1;
            endcase

            // Byte lexed afresh from idle.
            if (is_alpha(c))
            begin
                idle_res  = lex_char(c);
                has_idle  = 1'b1;
                idle_mode = MODE_NAME;
            end
            else if (is_digit(c))
            begin
                idle_res  = lex_char(c);
                has_idle  = 1'b1;
                idle_mode = MODE_INT;
            end
            else
            begin
                unique case (c)
                    CH_SLASH:   idle_mode = MODE_SLASH;
                    CH_EQUAL:   idle_mode = MODE_EQ;
                    CH_BANG:    idle_mode = MODE_BANG;
                    CH_PLUS:    idle_mode = MODE_PLUS;
                    CH_MINUS:   idle_mode = MODE_MINUS;
                    CH_LESS:    idle_mode = MODE_LT;
                    CH_GREATER: idle_mode = MODE_GT;
                    CH_AMP:     idle_mode = MODE_AMP;
                    CH_PIPE:    idle_mode = MODE_PIPE;
                    CH_STAR:
                    begin
                        idle_res = done(K_STAR);
                        has_idle = 1'b1;
                    end
                    CH_LPAREN:
                    begin
                        idle_res = done(K_LEFT_PAREN);
                        has_idle = 1'b1;
                    end
                    CH_RPAREN:
                    begin
                        idle_res = done(K_RIGHT_PAREN);
                        has_idle = 1'b1;
                    end
                    CH_SEMI:
                    begin
                        idle_res = done(K_SEMICOLON);
                        has_idle = 1'b1;
                    end
                    CH_LBRACE:
                    begin
                        idle_res = done(K_LEFT_BRACE);
                        has_idle = 1'b1;
                    end
                    CH_RBRACE:
                    begin
                        idle_res = done(K_RIGHT_BRACE);
                        has_idle = 1'b1;
                    end
                    default: ;  // whitespace and invalid bytes
                endcase
            end

            if (!again)
                has_idle = 1'b0;
            else
                mode_next = idle_mode;
        end
    end

    // Pack the up to two results in order and flag the final one.
    always_comb
    begin
        res0 = first_res;
        res1 = idle_res;
        if (!has_first)
            res0 = idle_res;
        push_n = 2'({1'b0, has_first} + {1'b0, has_idle});
        if (push_n == 2'd2)
            res1.last = 1'b1;
        else
            res0.last = 1'b1;
        if (!in_fire)
            push_n = 2'd0;
        count_next = count_reg + 3'(push_n) - 3'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                mode_reg <= mode_next;
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr_reg + 2'd1] <= res1;
    end

    assign chars.ready        = (count_reg <= 3'(DEPTH - 2));
    assign tokens.valid       = (count_reg != 3'd0);
    assign tokens.out_kind    = fifo_mem[rd_ptr_reg].out_kind;
    assign tokens.token_kind  = fifo_mem[rd_ptr_reg].token_kind;
    assign tokens.lexeme_char = fifo_mem[rd_ptr_reg].lexeme_char;
    assign tokens.last        = fifo_mem[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("result queue overflow");

    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && chars.end_of_input |=> mode_reg == MODE_IDLE)
        else $error("mode not idle after end of input");

    a_eoi_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && chars.end_of_input |-> push_n != 2'd0 && res0.out_kind == OUT_DONE)
        else $error("end of input gave no completion");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == 3'($past(count_reg) + 3'($past(push_n))
                                 - 3'($past(out_fire))))
        else $error("result count out of step");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire && count_reg == 3'd0 |=> !tokens.valid)
        else $error("result shown without a request");
`endif

endmodule
